@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; the macros expand to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/blpg_pkg.sv @@
// Types, widths and codes for the line pixel generator.
// No dependencies.
`default_nettype none

package blpg_pkg;

	localparam int COORD_BITS  = 12;
	localparam int ROW_PITCH_W = 16;
	localparam int BPP_W       = 4;
	localparam int COLOR_W     = 32;
	localparam int OFFSET_W    = 28;
	localparam int ERR_W       = COORD_BITS + 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = CFG_IDX_W'(2);

	localparam logic [ROW_PITCH_W-1:0] ROW_PITCH_RST = ROW_PITCH_W'(2560);
	localparam logic [BPP_W-1:0]       BPP_RST       = BPP_W'(4);
	localparam logic [COLOR_W-1:0]     COLOR_RST     = '0;

	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} line_cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

endpackage

`default_nettype wire

@@ hw/rtl/blpg_stepper.sv @@
// Bresenham stepper: line setup on start, one pixel step on advance.
// Depends on blpg_pkg.
`default_nettype none

module blpg_stepper
	import blpg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  line_cmd_t cmd,
	output logic      pix_valid,
	input  logic      pix_ready,
	output pixel_t    pix
);

	localparam int C = COORD_BITS;

	logic [C-1:0]            pos_x_q, pos_y_q;
	logic signed [ERR_W-1:0] err_q;
	logic [1:0]              step_x_q, step_y_q;
	logic [C-1:0]            major_q, minor_q;
	logic                    y_major_q;
	logic [C-1:0]            remaining_q;
	logic                    active_q;

	logic   valid_s2;
	pixel_t pix_s2;

	// setup
	logic signed [C:0]       dx, dy, ndx, ndy;
	logic [C-1:0]            adx, ady, maj0, min0;
	logic                    ymaj0;
	logic [1:0]              sx0, sy0;
	logic signed [ERR_W-1:0] err0;

	// step
	logic                    e_ge;
	logic signed [ERR_W-1:0] two_maj, two_min, err_nx;
	logic [C-1:0]            sx_ext, sy_ext, x_mv, y_mv, x_nx, y_nx, rem_nx;

	logic fire, is_start, produce;

	always_comb begin
		dx    = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
		dy    = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
		ndx   = -dx;
		ndy   = -dy;
		adx   = dx[C] ? ndx[C-1:0] : dx[C-1:0];
		ady   = dy[C] ? ndy[C-1:0] : dy[C-1:0];
		sx0   = (dx == '0) ? 2'b00 : (dx[C] ? 2'b11 : 2'b01);
		sy0   = (dy == '0) ? 2'b00 : (dy[C] ? 2'b11 : 2'b01);
		ymaj0 = ady > adx;
		maj0  = ymaj0 ? ady : adx;
		min0  = ymaj0 ? adx : ady;
		err0  = $signed({2'b00, min0, 1'b0}) - $signed({3'b000, maj0});
	end

	always_comb begin
		e_ge    = !err_q[ERR_W-1];
		two_maj = $signed({2'b00, major_q, 1'b0});
		two_min = $signed({2'b00, minor_q, 1'b0});
		err_nx  = err_q - (e_ge ? two_maj : '0) + two_min;
		sx_ext  = {{(C-2){step_x_q[1]}}, step_x_q};
		sy_ext  = {{(C-2){step_y_q[1]}}, step_y_q};
		x_mv    = pos_x_q + sx_ext;
		y_mv    = pos_y_q + sy_ext;
		// major axis always steps, minor only when the error went non-negative
		x_nx    = (!y_major_q || e_ge) ? x_mv : pos_x_q;
		y_nx    = (y_major_q || e_ge) ? y_mv : pos_y_q;
		rem_nx  = remaining_q - C'(1);
	end

	assign cmd_ready = !valid_s2 || pix_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign is_start  = (cmd.mode == MODE_START);
	assign produce   = is_start || active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			err_q       <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			major_q     <= '0;
			minor_q     <= '0;
			y_major_q   <= 1'b0;
			remaining_q <= '0;
			active_q    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (fire) begin
				valid_s2 <= produce;
				if (is_start) begin
					pos_x_q     <= cmd.x_start;
					pos_y_q     <= cmd.y_start;
					err_q       <= err0;
					step_x_q    <= sx0;
					step_y_q    <= sy0;
					major_q     <= maj0;
					minor_q     <= min0;
					y_major_q   <= ymaj0;
					remaining_q <= maj0;
					active_q    <= (maj0 != '0);
				end else if (active_q) begin
					pos_x_q     <= x_nx;
					pos_y_q     <= y_nx;
					err_q       <= err_nx;
					remaining_q <= rem_nx;
					active_q    <= (rem_nx != '0);
				end
			end else if (pix_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			if (is_start) begin
				pix_s2.x    <= cmd.x_start;
				pix_s2.y    <= cmd.y_start;
				pix_s2.last <= (maj0 == '0);
			end else begin
				pix_s2.x    <= x_nx;
				pix_s2.y    <= y_nx;
				pix_s2.last <= (rem_nx == '0);
			end
		end
	end

	assign pix_valid = valid_s2;
	assign pix       = pix_s2;

endmodule

`default_nettype wire

@@ hw/rtl/blpg_offset.sv @@
// Output stage: framebuffer byte offset and color, registered result word.
// Depends on blpg_pkg.
`default_nettype none

module blpg_offset
	import blpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  pixel_t                 pix,
	input  logic [ROW_PITCH_W-1:0] row_pitch,
	input  logic [BPP_W-1:0]       bytes_per_pixel,
	input  logic [COLOR_W-1:0]     draw_color,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_BITS-1:0]  pixel_x,
	output logic [COORD_BITS-1:0]  pixel_y,
	output logic [OFFSET_W-1:0]    byte_offset,
	output logic [COLOR_W-1:0]     pixel_color,
	output logic                   last
);

	logic [ROW_PITCH_W+COORD_BITS-1:0] prod_y;
	logic [BPP_W+COORD_BITS-1:0]       prod_x;
	logic [OFFSET_W-1:0]               offset;

	logic                  valid_s3;
	logic [COORD_BITS-1:0] x_s3, y_s3;
	logic [OFFSET_W-1:0]   offset_s3;
	logic [COLOR_W-1:0]    color_s3;
	logic                  last_s3;

	always_comb begin
		prod_y = row_pitch * pix.y;
		prod_x = bytes_per_pixel * pix.x;
		offset = OFFSET_W'(prod_y) + OFFSET_W'(prod_x);
	end

	assign pix_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (pix_ready) begin
			valid_s3 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			x_s3      <= pix.x;
			y_s3      <= pix.y;
			offset_s3 <= offset;
			color_s3  <= draw_color;
			last_s3   <= pix.last;
		end
	end

	assign out_valid   = valid_s3;
	assign pixel_x     = x_s3;
	assign pixel_y     = y_s3;
	assign byte_offset = offset_s3;
	assign pixel_color = color_s3;
	assign last        = last_s3;

endmodule

`default_nettype wire

@@ hw/rtl/bresenham_line_pixel_generator_unit.sv @@
// Top level of the Bresenham line pixel generator: input register,
// config registers, stepper and offset stage. Depends on blpg_pkg,
// blpg_stepper, blpg_offset and assert_macros.svh.
//
//   channel | signals                                 | word
//   --------+-----------------------------------------+---------------------------
//   input   | in_valid / in_ready                     | mode, x/y start, x/y end
//   output  | out_valid / out_ready                   | pixel x/y, offset, color, last
//   config  | cfg_we, cfg_index, cfg_data             | row pitch, bpp, draw color
//
// One input word per clock, sustained while out_ready is high. A result passes
// through the input, stepper and output registers in that order. Reset clears
// all valid bits and the stepper state (idle) and loads the config defaults.
// Each stage holds while the one after it is full and stalled, so in_ready
// drops only with all three stages occupied and out_ready low.
`default_nettype none
`include "assert_macros.svh"

module bresenham_line_pixel_generator_unit
	import blpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// config write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input words
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [COORD_BITS-1:0]  x_start,
	input  logic [COORD_BITS-1:0]  y_start,
	input  logic [COORD_BITS-1:0]  x_end,
	input  logic [COORD_BITS-1:0]  y_end,
	// result words
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_BITS-1:0]  pixel_x,
	output logic [COORD_BITS-1:0]  pixel_y,
	output logic [OFFSET_W-1:0]    byte_offset,
	output logic [COLOR_W-1:0]     pixel_color,
	output logic                   last
);

	// config registers; the user must write them only while the block is idle, the block does not enforce it
	logic [ROW_PITCH_W-1:0] row_pitch_q;
	logic [BPP_W-1:0]       bpp_q;
	logic [COLOR_W-1:0]     color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q <= ROW_PITCH_RST;
			bpp_q       <= BPP_RST;
			color_q     <= COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_PITCH:  row_pitch_q <= cfg_data[ROW_PITCH_W-1:0];
				REG_BPP:        bpp_q       <= cfg_data[BPP_W-1:0];
				REG_DRAW_COLOR: color_q     <= cfg_data[COLOR_W-1:0];
				default:        ; // unmapped index, write dropped
			endcase
		end
	end

	// input register: holds the word ahead of the stepper; in_ready is combinational through stp_ready
	logic      valid_s1;
	line_cmd_t cmd_s1;
	logic      stp_ready;

	assign in_ready = !valid_s1 || stp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.mode    <= mode;
			cmd_s1.x_start <= x_start;
			cmd_s1.y_start <= y_start;
			cmd_s1.x_end   <= x_end;
			cmd_s1.y_end   <= y_end;
		end
	end

	// stepper: start loads the line and emits the first pixel; advance
	// emits the next one, or nothing when no line is active
	logic   pix_valid;
	logic   pix_ready;
	pixel_t pix;

	blpg_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (valid_s1),
		.cmd_ready (stp_ready),
		.cmd       (cmd_s1),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// offset = row_pitch*y + bpp*x, low 28 bits; color copied at this stage
	blpg_offset u_offset (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_ready       (pix_ready),
		.pix             (pix),
		.row_pitch       (row_pitch_q),
		.bytes_per_pixel (bpp_q),
		.draw_color      (color_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.byte_offset     (byte_offset),
		.pixel_color     (pixel_color),
		.last            (last)
	);

	// a start word handed to the stepper always yields a pixel
	`ASSERT_NEXT(a_start_yields_pixel, clk, arst_n,
		valid_s1 && stp_ready && (cmd_s1.mode == MODE_START), pix_valid)

	// input stalls only when the stages behind it are full
	`ASSERT_IMP(a_stall_means_full, clk, arst_n,
		!in_ready, valid_s1 && pix_valid && out_valid)

	// a new result word comes only out of the stepper register
	`ASSERT_IMP(a_out_from_stepper, clk, arst_n,
		$rose(out_valid), $past(pix_valid))

endmodule

`default_nettype wire
